@@ hw/rtl/anagram_window_search_assert.svh @@
// assertion macros used by the anagram window search rtl
`ifndef ANAGRAM_WINDOW_SEARCH_ASSERT_SVH
`define ANAGRAM_WINDOW_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AWS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aws assertion failed: same-cycle implication");
// next-cycle implication
`define AWS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aws assertion failed: next-cycle implication");
`else
`define AWS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define AWS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/aws_pkg.sv @@
package aws_pkg;

	// alphabet and text storage
	localparam int ALPHABET = 26;
	localparam int LETTER_W = 5;
	localparam int HIST_AW  = $clog2(ALPHABET);
	localparam int MAX_TEXT = 256;
	localparam int TEXT_AW  = $clog2(MAX_TEXT);
	localparam int POS_W    = TEXT_AW + 1;
	localparam int PLEN_W   = TEXT_AW;
	localparam int CNT_W    = POS_W;
	localparam int DIFF_W   = $clog2(ALPHABET + 1);
	localparam int START_W  = 8;

	// result queue
	localparam int FIFO_N   = 4;
	localparam int FIFO_AW  = $clog2(FIFO_N);
	localparam int FIFO_CW  = $clog2(FIFO_N + 3);

	typedef logic [HIST_AW-1:0]  hidx_t;
	typedef logic [TEXT_AW-1:0]  taddr_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [PLEN_W-1:0]   plen_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [DIFF_W-1:0]   diff_t;
	typedef logic [START_W-1:0]  start_t;
	typedef logic [FIFO_AW-1:0]  fptr_t;
	typedef logic [FIFO_CW-1:0]  fcnt_t;

	typedef enum logic [1:0] {
		ACT_PATTERN = 2'd0,
		ACT_TEXT    = 2'd1,
		ACT_END     = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef struct packed {
		action_t              action;
		logic [LETTER_W-1:0]  letter;
	} cmd_t;

	typedef struct packed {
		start_t  start_pos;
		logic    is_end;
		logic    none_found;
	} res_t;

	// one write port of a histogram memory
	typedef struct packed {
		logic   we;
		hidx_t  addr;
		cnt_t   data;
	} hist_wr_t;

endpackage

@@ hw/rtl/aws_hist_ram.sv @@
// letter histogram memory: one write port, two registered read ports,
// write-first bypass, per-entry valid bits so a clear resets every entry at once
module aws_hist_ram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  aws_pkg::hist_wr_t  wr,
	input  aws_pkg::hidx_t     raddr_a,
	input  aws_pkg::hidx_t     raddr_b,
	output aws_pkg::cnt_t      rdata_a,
	output aws_pkg::cnt_t      rdata_b
);

	aws_pkg::cnt_t                mem [aws_pkg::ALPHABET];
	logic [aws_pkg::ALPHABET-1:0] valid_q;
	aws_pkg::cnt_t                rd_a_q;
	aws_pkg::cnt_t                rd_b_q;

	// entry valid bits, an invalid entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (wr.we && !clr) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read ports, a same-cycle write or clear wins
	always_ff @(posedge clk) begin
		if (clr) begin
			rd_a_q <= '0;
		end else if (wr.we && wr.addr == raddr_a) begin
			rd_a_q <= wr.data;
		end else if (valid_q[raddr_a]) begin
			rd_a_q <= mem[raddr_a];
		end else begin
			rd_a_q <= '0;
		end
		if (clr) begin
			rd_b_q <= '0;
		end else if (wr.we && wr.addr == raddr_b) begin
			rd_b_q <= wr.data;
		end else if (valid_q[raddr_b]) begin
			rd_b_q <= mem[raddr_b];
		end else begin
			rd_b_q <= '0;
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ hw/rtl/aws_text_ram.sv @@
// stored text letters, one write and one registered read per cycle
module aws_text_ram (
	input  logic             clk,
	input  logic             we,
	input  aws_pkg::taddr_t  waddr,
	input  aws_pkg::hidx_t   wdata,
	input  aws_pkg::taddr_t  raddr,
	output aws_pkg::hidx_t   rdata
);

	aws_pkg::hidx_t mem [aws_pkg::MAX_TEXT];
	aws_pkg::hidx_t rd_q;

	// write and read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

@@ hw/rtl/anagram_window_search.sv @@
// anagram window search
// cmd channel (cmd_valid/cmd_ready/cmd): one beat per action. pattern letters
// build the pattern histogram while no text is open; text letters slide a
// window as long as the pattern; end of text closes the text; clear all
// returns the block to its reset state. letters outside the alphabet, pattern
// letters once text has begun, and letters past the storage bound are dropped.
// res channel (res_valid/res_ready/res): a match beat carries the window start,
// the end-of-text beat carries is_end and none_found.
// results pass stage 1 and stage 2 before they enter the result buffer.
// throughput: one beat per cycle, sustained while res_ready stays high. each
// beat reads the text memory once, then both ports of the three histogram
// memories in stage 1, and writes them back in stage 2.
// stall: results queue in a four-entry buffer; cmd_ready drops once the buffer
// plus the two pipeline stages could fill it, and rises as res beats drain.
// reset: arst_n clears all control state and the histogram valid bits at once;
// no clearing pass is needed and cmd_ready is high in the first cycle after.
`include "anagram_window_search_assert.svh"
module anagram_window_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  aws_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output aws_pkg::res_t  res
);

	typedef struct packed {
		aws_pkg::action_t  op;
		aws_pkg::hidx_t    letter;
		logic              has_old;
		logic              empty;
		logic              chk;
		aws_pkg::start_t   start;
	} stg_t;

	// front state, updated at accept
	aws_pkg::pos_t   pos_q;
	aws_pkg::plen_t  plen_q;

	// pipeline
	logic            v_s1;
	logic            v_s2;
	stg_t            stg_s1;
	stg_t            stg_s2;
	aws_pkg::hidx_t  old_s2;

	// match state
	aws_pkg::diff_t  diff_q;
	aws_pkg::diff_t  npres_q;
	logic            found_q;

	// result queue
	aws_pkg::res_t   fifo_q [aws_pkg::FIFO_N];
	aws_pkg::fptr_t  wr_q;
	aws_pkg::fptr_t  rd_q;
	aws_pkg::fcnt_t  fifo_cnt_q;

	logic            cmd_acc;
	logic            letter_ok;
	logic            pat_ok;
	logic            txt_ok;
	logic            take;
	aws_pkg::pos_t   len_ext;
	aws_pkg::pos_t   p1;
	aws_pkg::pos_t   old_pos;
	aws_pkg::fcnt_t  load;
	stg_t            ent;
	logic            text_we;
	aws_pkg::hidx_t  text_rd;
	aws_pkg::hidx_t  raddr_b;

	aws_pkg::cnt_t   pa, pb, ia, ib, oa, ob;
	aws_pkg::cnt_t   wa, wb;
	logic            is_txt, is_pat, is_end, is_clr;
	logic            same;
	logic            up_a, dn_a, up_b, dn_b;
	aws_pkg::diff_t  diff_new;
	logic            res_push;
	logic            res_pop;
	logic            fifo_full;
	aws_pkg::res_t   res_in;
	aws_pkg::hist_wr_t pat_wr, in_wr, out_wr;
	logic            win_clr;

	// input decode and admission
	assign load      = aws_pkg::fcnt_t'(fifo_cnt_q + aws_pkg::fcnt_t'(v_s1)
		+ aws_pkg::fcnt_t'(v_s2));
	assign cmd_ready = load < aws_pkg::fcnt_t'(aws_pkg::FIFO_N);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign letter_ok = int'(cmd.letter) < aws_pkg::ALPHABET;
	assign pat_ok    = cmd.action == aws_pkg::ACT_PATTERN && letter_ok && pos_q == '0
		&& plen_q != aws_pkg::plen_t'(aws_pkg::MAX_TEXT - 1);
	assign txt_ok    = cmd.action == aws_pkg::ACT_TEXT && letter_ok
		&& pos_q < aws_pkg::pos_t'(aws_pkg::MAX_TEXT);
	assign take      = pat_ok || txt_ok || cmd.action == aws_pkg::ACT_END
		|| cmd.action == aws_pkg::ACT_CLEAR;

	// window geometry for a text letter
	assign len_ext = aws_pkg::pos_t'(plen_q);
	assign p1      = pos_q + aws_pkg::pos_t'(1);
	assign old_pos = pos_q - len_ext;

	always_comb begin
		ent.op      = cmd.action;
		ent.letter  = aws_pkg::hidx_t'(cmd.letter);
		ent.empty   = plen_q == '0;
		ent.has_old = plen_q != '0 && pos_q >= len_ext;
		ent.chk     = p1 >= len_ext;
		ent.start   = (plen_q == '0) ? aws_pkg::start_t'(pos_q)
			: aws_pkg::start_t'(p1 - len_ext);
	end

	// front counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			plen_q <= '0;
		end else if (cmd_acc) begin
			unique case (cmd.action)
				aws_pkg::ACT_CLEAR: begin
					pos_q  <= '0;
					plen_q <= '0;
				end
				aws_pkg::ACT_END: begin
					pos_q <= '0;
				end
				aws_pkg::ACT_PATTERN: begin
					if (pat_ok) begin
						plen_q <= plen_q + aws_pkg::plen_t'(1);
					end
				end
				aws_pkg::ACT_TEXT: begin
					if (txt_ok) begin
						pos_q <= p1;
					end
				end
			endcase
		end
	end

	// text store, read of the leaving letter
	assign text_we = cmd_acc && txt_ok;

	aws_text_ram u_text (
		.clk   (clk),
		.we    (text_we),
		.waddr (aws_pkg::taddr_t'(pos_q)),
		.wdata (aws_pkg::hidx_t'(cmd.letter)),
		.raddr (aws_pkg::taddr_t'(old_pos)),
		.rdata (text_rd)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd_acc && take;
			v_s2 <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			stg_s1 <= ent;
		end
		stg_s2 <= stg_s1;
		old_s2 <= text_rd;
	end

	// histogram reads issued in stage 1
	assign raddr_b = stg_s1.has_old ? text_rd : stg_s1.letter;

	aws_hist_ram u_pat (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (is_clr),
		.wr      (pat_wr),
		.raddr_a (stg_s1.letter),
		.raddr_b (raddr_b),
		.rdata_a (pa),
		.rdata_b (pb)
	);

	aws_hist_ram u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (win_clr),
		.wr      (in_wr),
		.raddr_a (stg_s1.letter),
		.raddr_b (raddr_b),
		.rdata_a (ia),
		.rdata_b (ib)
	);

	aws_hist_ram u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (win_clr),
		.wr      (out_wr),
		.raddr_a (stg_s1.letter),
		.raddr_b (raddr_b),
		.rdata_a (oa),
		.rdata_b (ob)
	);

	// stage 2 decode
	assign is_txt  = v_s2 && stg_s2.op == aws_pkg::ACT_TEXT && !stg_s2.empty;
	assign is_pat  = v_s2 && stg_s2.op == aws_pkg::ACT_PATTERN;
	assign is_end  = v_s2 && stg_s2.op == aws_pkg::ACT_END;
	assign is_clr  = v_s2 && stg_s2.op == aws_pkg::ACT_CLEAR;
	assign win_clr = is_clr || is_end;

	// window count is entered minus left
	assign wa   = ia - oa;
	assign wb   = ib - ob;
	assign same = stg_s2.has_old && old_s2 == stg_s2.letter;
	assign up_a = wa == pa;
	assign dn_a = (wa + aws_pkg::cnt_t'(1)) == pa;
	assign up_b = stg_s2.has_old && wb == pb;
	assign dn_b = stg_s2.has_old && (wb - aws_pkg::cnt_t'(1)) == pb;

	// differing-letter count after the slide
	always_comb begin
		if (same) begin
			diff_new = diff_q;
		end else begin
			diff_new = diff_q + aws_pkg::diff_t'(up_a) + aws_pkg::diff_t'(up_b)
				- aws_pkg::diff_t'(dn_a) - aws_pkg::diff_t'(dn_b);
		end
	end

	// histogram write-back
	always_comb begin
		pat_wr.we   = is_pat;
		pat_wr.addr = stg_s2.letter;
		pat_wr.data = pa + aws_pkg::cnt_t'(1);
		in_wr.we    = is_txt;
		in_wr.addr  = stg_s2.letter;
		in_wr.data  = ia + aws_pkg::cnt_t'(1);
		out_wr.we   = is_txt && stg_s2.has_old;
		out_wr.addr = old_s2;
		out_wr.data = ob + aws_pkg::cnt_t'(1);
	end

	// result beat
	assign res_push = is_end || (v_s2 && stg_s2.op == aws_pkg::ACT_TEXT
		&& (stg_s2.empty || (stg_s2.chk && diff_new == '0)));

	always_comb begin
		res_in.start_pos  = is_end ? '0 : stg_s2.start;
		res_in.is_end     = is_end;
		res_in.none_found = is_end && !found_q;
	end

	// match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q  <= '0;
			npres_q <= '0;
			found_q <= 1'b0;
		end else if (is_clr) begin
			diff_q  <= '0;
			npres_q <= '0;
			found_q <= 1'b0;
		end else if (is_end) begin
			diff_q  <= npres_q;
			found_q <= 1'b0;
		end else if (is_pat) begin
			if (pa == '0) begin
				diff_q  <= diff_q + aws_pkg::diff_t'(1);
				npres_q <= npres_q + aws_pkg::diff_t'(1);
			end
		end else if (is_txt) begin
			diff_q <= diff_new;
			if (res_push) begin
				found_q <= 1'b1;
			end
		end else if (res_push) begin
			found_q <= 1'b1;
		end
	end

	// result queue
	assign res_pop   = res_valid && res_ready;
	assign res_valid = fifo_cnt_q != '0;
	assign res       = fifo_q[rd_q];
	assign fifo_full = fifo_cnt_q == aws_pkg::fcnt_t'(aws_pkg::FIFO_N);

	always_ff @(posedge clk) begin
		if (res_push) begin
			fifo_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (res_push) begin
				wr_q <= wr_q + aws_pkg::fptr_t'(1);
			end
			if (res_pop) begin
				rd_q <= rd_q + aws_pkg::fptr_t'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + aws_pkg::fcnt_t'(res_push)
				- aws_pkg::fcnt_t'(res_pop);
		end
	end

	// checks
	`AWS_ASSERT_NEXT(a_stage_flow, clk, arst_n, v_s1, v_s2)
	`AWS_ASSERT_IMPLIES(a_fifo_room, clk, arst_n, res_push, !fifo_full || res_pop)
	`AWS_ASSERT_IMPLIES(a_text_bound, clk, arst_n, text_we, !pos_q[aws_pkg::TEXT_AW])
	`AWS_ASSERT_IMPLIES(a_diff_range, clk, arst_n, 1'b1, int'(diff_q) <= aws_pkg::ALPHABET)

endmodule
